/* src/tpc_pkg.sv */
package tpc_pkg;

    localparam int DATA_W = 64;
    localparam int RF_DEPTH = 8;
    localparam int PC_W = 7;
    localparam int SH_W = 6;

    localparam logic [PC_W-1:0] PC_TEMP = 7'd0;
    localparam logic [PC_W-1:0] PC_PRESS = 7'd32;

    localparam logic [2:0] CFG_TEMP_CAL_1 = 3'd0;
    localparam logic [2:0] CFG_TEMP_CAL_2_3 = 3'd1;
    localparam logic [2:0] CFG_PRESS_CAL_1 = 3'd2;
    localparam logic [2:0] CFG_PRESS_CAL_2_3 = 3'd3;
    localparam logic [2:0] CFG_PRESS_CAL_4_5 = 3'd4;
    localparam logic [2:0] CFG_PRESS_CAL_6_7 = 3'd5;
    localparam logic [2:0] CFG_PRESS_CAL_8_9 = 3'd6;

    typedef enum logic [3:0] {
        OP_LDK, OP_ADD, OP_SUB, OP_MUL, OP_SHL, OP_ASR, OP_DIV, OP_SAT, OP_STF, OP_END
    } t_op;

    typedef enum logic [4:0] {
        SRC_ADC, SRC_FINE, SRC_ONE, SRC_T1, SRC_T2, SRC_T3,
        SRC_P1, SRC_P2, SRC_P3, SRC_P4, SRC_P5, SRC_P6, SRC_P7, SRC_P8, SRC_P9,
        SRC_K5, SRC_K128, SRC_K3125, SRC_K128000, SRC_K1048576
    } t_src;

    typedef logic [2:0] t_reg;

    typedef struct packed {
        t_op             op;
        t_reg            rd;
        t_reg            ra;
        t_reg            rb;
        t_src            src;
        logic [SH_W-1:0] sh;
    } t_uop;

    typedef struct packed {
        logic take;
        logic go;
        t_uop uop;
    } t_cmd;

    typedef struct packed {
        logic done;
        logic dz;
    } t_stat;

    function automatic t_uop f_ldk(input t_reg rd, input t_src src);
        t_uop u;
        u = '{op: OP_LDK, rd: rd, ra: 3'd0, rb: 3'd0, src: src, sh: '0};
        return u;
    endfunction

    function automatic t_uop f_alu(input t_op op, input t_reg rd, input t_reg ra,
                                   input t_reg rb);
        t_uop u;
        u = '{op: op, rd: rd, ra: ra, rb: rb, src: SRC_ONE, sh: '0};
        return u;
    endfunction

    function automatic t_uop f_sh(input t_op op, input t_reg rd, input t_reg ra,
                                  input logic [SH_W-1:0] sh);
        t_uop u;
        u = '{op: op, rd: rd, ra: ra, rb: 3'd0, src: SRC_ONE, sh: sh};
        return u;
    endfunction

    // Microprogram: temperature from PC_TEMP, pressure from PC_PRESS.
    function automatic t_uop f_ucode(input logic [PC_W-1:0] pc);
        t_uop u;
        case (pc)
            7'd0:  u = f_ldk(3'd0, SRC_ADC);
            7'd1:  u = f_sh(OP_ASR, 3'd1, 3'd0, 6'd3);
            7'd2:  u = f_ldk(3'd2, SRC_T1);
            7'd3:  u = f_sh(OP_SHL, 3'd3, 3'd2, 6'd1);
            7'd4:  u = f_alu(OP_SUB, 3'd1, 3'd1, 3'd3);
            7'd5:  u = f_sh(OP_ASR, 3'd0, 3'd0, 6'd4);
            7'd6:  u = f_alu(OP_SUB, 3'd0, 3'd0, 3'd2);
            7'd7:  u = f_ldk(3'd2, SRC_T2);
            7'd8:  u = f_alu(OP_MUL, 3'd1, 3'd1, 3'd2);
            7'd9:  u = f_sh(OP_ASR, 3'd1, 3'd1, 6'd11);
            7'd10: u = f_alu(OP_MUL, 3'd0, 3'd0, 3'd0);
            7'd11: u = f_sh(OP_ASR, 3'd0, 3'd0, 6'd12);
            7'd12: u = f_ldk(3'd2, SRC_T3);
            7'd13: u = f_alu(OP_MUL, 3'd0, 3'd0, 3'd2);
            7'd14: u = f_sh(OP_ASR, 3'd0, 3'd0, 6'd14);
            7'd15: u = f_alu(OP_ADD, 3'd0, 3'd0, 3'd1);
            7'd16: u = f_alu(OP_SAT, 3'd0, 3'd0, 3'd0);
            7'd17: u = f_alu(OP_STF, 3'd0, 3'd0, 3'd0);
            7'd18: u = f_ldk(3'd1, SRC_K5);
            7'd19: u = f_alu(OP_MUL, 3'd0, 3'd0, 3'd1);
            7'd20: u = f_ldk(3'd1, SRC_K128);
            7'd21: u = f_alu(OP_ADD, 3'd0, 3'd0, 3'd1);
            7'd22: u = f_sh(OP_ASR, 3'd0, 3'd0, 6'd8);
            7'd23: u = f_alu(OP_SAT, 3'd0, 3'd0, 3'd0);
            7'd24: u = f_alu(OP_END, 3'd0, 3'd0, 3'd0);
            7'd32: u = f_ldk(3'd0, SRC_FINE);
            7'd33: u = f_ldk(3'd1, SRC_K128000);
            7'd34: u = f_alu(OP_SUB, 3'd0, 3'd0, 3'd1);
            7'd35: u = f_alu(OP_MUL, 3'd1, 3'd0, 3'd0);
            7'd36: u = f_ldk(3'd2, SRC_P6);
            7'd37: u = f_alu(OP_MUL, 3'd2, 3'd1, 3'd2);
            7'd38: u = f_ldk(3'd3, SRC_P5);
            7'd39: u = f_alu(OP_MUL, 3'd3, 3'd0, 3'd3);
            7'd40: u = f_sh(OP_SHL, 3'd3, 3'd3, 6'd17);
            7'd41: u = f_alu(OP_ADD, 3'd2, 3'd2, 3'd3);
            7'd42: u = f_ldk(3'd3, SRC_P4);
            7'd43: u = f_sh(OP_SHL, 3'd3, 3'd3, 6'd35);
            7'd44: u = f_alu(OP_ADD, 3'd2, 3'd2, 3'd3);
            7'd45: u = f_ldk(3'd3, SRC_P3);
            7'd46: u = f_alu(OP_MUL, 3'd3, 3'd1, 3'd3);
            7'd47: u = f_sh(OP_ASR, 3'd3, 3'd3, 6'd8);
            7'd48: u = f_ldk(3'd4, SRC_P2);
            7'd49: u = f_alu(OP_MUL, 3'd4, 3'd0, 3'd4);
            7'd50: u = f_sh(OP_SHL, 3'd4, 3'd4, 6'd12);
            7'd51: u = f_alu(OP_ADD, 3'd0, 3'd3, 3'd4);
            7'd52: u = f_ldk(3'd1, SRC_ONE);
            7'd53: u = f_sh(OP_SHL, 3'd1, 3'd1, 6'd47);
            7'd54: u = f_alu(OP_ADD, 3'd0, 3'd0, 3'd1);
            7'd55: u = f_ldk(3'd1, SRC_P1);
            7'd56: u = f_alu(OP_MUL, 3'd0, 3'd0, 3'd1);
            7'd57: u = f_sh(OP_ASR, 3'd0, 3'd0, 6'd33);
            7'd58: u = f_ldk(3'd1, SRC_K1048576);
            7'd59: u = f_ldk(3'd3, SRC_ADC);
            7'd60: u = f_alu(OP_SUB, 3'd1, 3'd1, 3'd3);
            7'd61: u = f_sh(OP_SHL, 3'd1, 3'd1, 6'd31);
            7'd62: u = f_alu(OP_SUB, 3'd1, 3'd1, 3'd2);
            7'd63: u = f_ldk(3'd3, SRC_K3125);
            7'd64: u = f_alu(OP_MUL, 3'd1, 3'd1, 3'd3);
            7'd65: u = f_alu(OP_DIV, 3'd1, 3'd1, 3'd0);
            7'd66: u = f_sh(OP_ASR, 3'd2, 3'd1, 6'd13);
            7'd67: u = f_alu(OP_MUL, 3'd3, 3'd2, 3'd2);
            7'd68: u = f_ldk(3'd4, SRC_P9);
            7'd69: u = f_alu(OP_MUL, 3'd3, 3'd3, 3'd4);
            7'd70: u = f_sh(OP_ASR, 3'd3, 3'd3, 6'd25);
            7'd71: u = f_ldk(3'd4, SRC_P8);
            7'd72: u = f_alu(OP_MUL, 3'd4, 3'd4, 3'd1);
            7'd73: u = f_sh(OP_ASR, 3'd4, 3'd4, 6'd19);
            7'd74: u = f_alu(OP_ADD, 3'd1, 3'd1, 3'd3);
            7'd75: u = f_alu(OP_ADD, 3'd1, 3'd1, 3'd4);
            7'd76: u = f_sh(OP_ASR, 3'd1, 3'd1, 6'd8);
            7'd77: u = f_ldk(3'd4, SRC_P7);
            7'd78: u = f_sh(OP_SHL, 3'd4, 3'd4, 6'd4);
            7'd79: u = f_alu(OP_ADD, 3'd1, 3'd1, 3'd4);
            7'd80: u = f_alu(OP_SAT, 3'd1, 3'd1, 3'd0);
            7'd81: u = f_alu(OP_END, 3'd0, 3'd1, 3'd0);
            default: u = f_alu(OP_END, 3'd0, 3'd0, 3'd0);
        endcase
        return u;
    endfunction

endpackage

/* src/tpc_req_if.sv */
interface tpc_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [19:0] raw_reading;

    modport source(output valid, output req_type, output raw_reading, input ready);
    modport sink(input valid, input req_type, input raw_reading, output ready);
endinterface

/* src/tpc_res_if.sv */
interface tpc_res_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] result_value;
    logic signed [31:0] fine_temp_out;
    logic               div_zero;

    modport source(output valid, output result_value, output fine_temp_out,
                   output div_zero, input ready);
    modport sink(input valid, input result_value, input fine_temp_out,
                 input div_zero, output ready);
endinterface

/* src/tpc_ram.sv */
module tpc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* src/tpc_div.sv */
module tpc_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_num,
    input  logic [63:0] i_den,
    output logic        o_done,
    output logic [63:0] o_quo
);
    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [64:0] r_rem;
    logic [63:0] r_q;
    logic [63:0] r_den;
    logic        r_neg;
    logic [64:0] n_sh;
    logic        n_bit;

    // Restoring division on magnitudes, one quotient bit per cycle.
    assign n_sh  = {r_rem[63:0], r_q[63]};
    assign n_bit = (n_sh >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_q    <= i_num[63] ? (64'd0 - i_num) : i_num;
                r_den  <= i_den[63] ? (64'd0 - i_den) : i_den;
                r_neg  <= i_num[63] ^ i_den[63];
            end else if (r_busy) begin
                r_rem <= n_bit ? (n_sh - {1'b0, r_den}) : n_sh;
                r_q   <= {r_q[62:0], n_bit};
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_neg ? (64'd0 - r_q) : r_q;
endmodule

/* src/tpc_datapath.sv */
module tpc_datapath (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tpc_pkg::t_cmd    i_cmd,
    input  logic [19:0]      i_raw,
    input  logic             i_cfg_we,
    input  logic [2:0]       i_cfg_index,
    input  logic [31:0]      i_cfg_data,
    output tpc_pkg::t_stat   o_stat,
    output logic [31:0]      o_result,
    output logic [31:0]      o_fine
);
    logic [15:0] r_t1, r_p1;
    logic [31:0] r_t23, r_p23, r_p45, r_p67, r_p89;
    logic [19:0] r_adc;
    logic [31:0] r_fine;
    logic [31:0] r_res;
    logic        r_done;
    logic        r_dz;

    logic [63:0] r_ma, r_mb, r_acc, r_prod;
    logic [2:0]  r_mstep;
    logic [2:0]  r_mrd;
    logic [2:0]  r_drd;

    logic [63:0] a, b, n_src, n_alu;
    logic        n_alu_we;
    logic        n_we;
    logic [2:0]  n_waddr;
    logic [63:0] n_wdata;
    logic        div_start, div_done;
    logic [63:0] div_quo;
    tpc_pkg::t_uop u;

    assign u = i_cmd.uop;

    function automatic logic [63:0] sx16(input logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

    always_comb begin
        case (u.src)
            tpc_pkg::SRC_ADC:      n_src = {44'd0, r_adc};
            tpc_pkg::SRC_FINE:     n_src = {{32{r_fine[31]}}, r_fine};
            tpc_pkg::SRC_ONE:      n_src = 64'd1;
            tpc_pkg::SRC_T1:       n_src = {48'd0, r_t1};
            tpc_pkg::SRC_T2:       n_src = sx16(r_t23[15:0]);
            tpc_pkg::SRC_T3:       n_src = sx16(r_t23[31:16]);
            tpc_pkg::SRC_P1:       n_src = {48'd0, r_p1};
            tpc_pkg::SRC_P2:       n_src = sx16(r_p23[15:0]);
            tpc_pkg::SRC_P3:       n_src = sx16(r_p23[31:16]);
            tpc_pkg::SRC_P4:       n_src = sx16(r_p45[15:0]);
            tpc_pkg::SRC_P5:       n_src = sx16(r_p45[31:16]);
            tpc_pkg::SRC_P6:       n_src = sx16(r_p67[15:0]);
            tpc_pkg::SRC_P7:       n_src = sx16(r_p67[31:16]);
            tpc_pkg::SRC_P8:       n_src = sx16(r_p89[15:0]);
            tpc_pkg::SRC_P9:       n_src = sx16(r_p89[31:16]);
            tpc_pkg::SRC_K5:       n_src = 64'd5;
            tpc_pkg::SRC_K128:     n_src = 64'd128;
            tpc_pkg::SRC_K3125:    n_src = 64'd3125;
            tpc_pkg::SRC_K128000:  n_src = 64'd128000;
            tpc_pkg::SRC_K1048576: n_src = 64'd1048576;
            default:               n_src = 64'd0;
        endcase
    end

    always_comb begin
        n_alu    = a;
        n_alu_we = 1'b0;
        case (u.op)
            tpc_pkg::OP_LDK: begin
                n_alu    = n_src;
                n_alu_we = 1'b1;
            end
            tpc_pkg::OP_ADD: begin
                n_alu    = a + b;
                n_alu_we = 1'b1;
            end
            tpc_pkg::OP_SUB: begin
                n_alu    = a - b;
                n_alu_we = 1'b1;
            end
            tpc_pkg::OP_SHL: begin
                n_alu    = a << u.sh;
                n_alu_we = 1'b1;
            end
            tpc_pkg::OP_ASR: begin
                n_alu    = 64'($signed(a) >>> u.sh);
                n_alu_we = 1'b1;
            end
            tpc_pkg::OP_SAT: begin
                // Clamp to the signed 32-bit range, kept sign-extended.
                if (a[63:31] == {33{a[63]}}) begin
                    n_alu = a;
                end else if (a[63]) begin
                    n_alu = 64'hFFFF_FFFF_8000_0000;
                end else begin
                    n_alu = 64'h0000_0000_7FFF_FFFF;
                end
                n_alu_we = 1'b1;
            end
            default: begin
                n_alu    = a;
                n_alu_we = 1'b0;
            end
        endcase
    end

    assign div_start = i_cmd.go && (u.op == tpc_pkg::OP_DIV) && (b != 64'd0);

    always_comb begin
        if (div_done) begin
            n_we    = 1'b1;
            n_waddr = r_drd;
            n_wdata = div_quo;
        end else if (r_mstep == 3'd4) begin
            n_we    = 1'b1;
            n_waddr = r_mrd;
            n_wdata = r_acc + {r_prod[31:0], 32'd0};
        end else begin
            n_we    = i_cmd.go && n_alu_we;
            n_waddr = u.rd;
            n_wdata = n_alu;
        end
    end

    tpc_ram #(.WIDTH(tpc_pkg::DATA_W), .DEPTH(tpc_pkg::RF_DEPTH)) u_rf_a (
        .i_clk   (i_clk),
        .i_we    (n_we),
        .i_waddr (n_waddr),
        .i_wdata (n_wdata),
        .i_raddr (u.ra),
        .o_rdata (a)
    );

    tpc_ram #(.WIDTH(tpc_pkg::DATA_W), .DEPTH(tpc_pkg::RF_DEPTH)) u_rf_b (
        .i_clk   (i_clk),
        .i_we    (n_we),
        .i_waddr (n_waddr),
        .i_wdata (n_wdata),
        .i_raddr (u.rb),
        .o_rdata (b)
    );

    tpc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (a),
        .i_den   (b),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1    <= '0;
            r_t23   <= '0;
            r_p1    <= '0;
            r_p23   <= '0;
            r_p45   <= '0;
            r_p67   <= '0;
            r_p89   <= '0;
            r_fine  <= '0;
            r_done  <= 1'b0;
            r_dz    <= 1'b0;
            r_mstep <= '0;
        end else begin
            r_done <= 1'b0;
            r_dz   <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    tpc_pkg::CFG_TEMP_CAL_1:    r_t1  <= i_cfg_data[15:0];
                    tpc_pkg::CFG_TEMP_CAL_2_3:  r_t23 <= i_cfg_data;
                    tpc_pkg::CFG_PRESS_CAL_1:   r_p1  <= i_cfg_data[15:0];
                    tpc_pkg::CFG_PRESS_CAL_2_3: r_p23 <= i_cfg_data;
                    tpc_pkg::CFG_PRESS_CAL_4_5: r_p45 <= i_cfg_data;
                    tpc_pkg::CFG_PRESS_CAL_6_7: r_p67 <= i_cfg_data;
                    tpc_pkg::CFG_PRESS_CAL_8_9: r_p89 <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.take) begin
                r_adc <= i_raw;
            end
            if (i_cmd.go) begin
                case (u.op)
                    tpc_pkg::OP_STF: r_fine <= a[31:0];
                    tpc_pkg::OP_END: r_res  <= a[31:0];
                    tpc_pkg::OP_MUL: begin
                        r_ma    <= a;
                        r_mb    <= b;
                        r_mrd   <= u.rd;
                        r_acc   <= '0;
                        r_mstep <= 3'd1;
                    end
                    tpc_pkg::OP_DIV: begin
                        r_drd <= u.rd;
                        if (b == 64'd0) begin
                            r_res  <= '0;
                            r_done <= 1'b1;
                            r_dz   <= 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            // Low 64 bits of the product from three 32x32 partial products.
            case (r_mstep)
                3'd1: begin
                    r_prod  <= r_ma[31:0] * r_mb[31:0];
                    r_mstep <= 3'd2;
                end
                3'd2: begin
                    r_acc   <= r_acc + r_prod;
                    r_prod  <= r_ma[31:0] * r_mb[63:32];
                    r_mstep <= 3'd3;
                end
                3'd3: begin
                    r_acc   <= r_acc + {r_prod[31:0], 32'd0};
                    r_prod  <= r_ma[63:32] * r_mb[31:0];
                    r_mstep <= 3'd4;
                end
                3'd4: begin
                    r_done  <= 1'b1;
                    r_mstep <= 3'd0;
                end
                default: ;
            endcase
            if (div_done) begin
                r_done <= 1'b1;
            end
        end
    end

    assign o_stat   = '{done: r_done, dz: r_dz};
    assign o_result = r_res;
    assign o_fine   = r_fine;
endmodule

/* src/tpc_ctrl.sv */
module tpc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    input  logic           i_req_type,
    input  logic           i_res_ready,
    input  tpc_pkg::t_stat i_stat,
    output logic           o_req_ready,
    output logic           o_res_valid,
    output logic           o_div_zero,
    output tpc_pkg::t_cmd  o_cmd
);
    typedef enum logic [2:0] {S_IDLE, S_READ, S_ISSUE, S_WAIT, S_OUT} t_state;

    t_state                    r_state;
    logic [tpc_pkg::PC_W-1:0]  r_pc;
    logic                      r_dz;
    tpc_pkg::t_uop             u;
    logic                      take;

    assign u    = tpc_pkg::f_ucode(r_pc);
    assign take = (r_state == S_IDLE) && i_req_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pc    <= '0;
            r_dz    <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_req_valid) begin
                        r_pc    <= i_req_type ? tpc_pkg::PC_PRESS : tpc_pkg::PC_TEMP;
                        r_dz    <= 1'b0;
                        r_state <= S_READ;
                    end
                end
                S_READ: r_state <= S_ISSUE;
                S_ISSUE: begin
                    if (u.op == tpc_pkg::OP_END) begin
                        r_state <= S_OUT;
                    end else if (u.op == tpc_pkg::OP_MUL || u.op == tpc_pkg::OP_DIV) begin
                        r_state <= S_WAIT;
                    end else begin
                        r_pc    <= r_pc + 7'd1;
                        r_state <= S_READ;
                    end
                end
                S_WAIT: begin
                    if (i_stat.done) begin
                        if (i_stat.dz) begin
                            r_dz    <= 1'b1;
                            r_state <= S_OUT;
                        end else begin
                            r_pc    <= r_pc + 7'd1;
                            r_state <= S_READ;
                        end
                    end
                end
                S_OUT: begin
                    if (i_res_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_cmd       = '{take: take, go: (r_state == S_ISSUE), uop: u};
    assign o_req_ready = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_OUT);
    assign o_div_zero  = r_dz;
endmodule

/* src/temp_pressure_compensation.sv */
// Temperature and pressure compensation for a 20-bit sensor converter.
// Requests arrive on i_req_ch (req_type 0 = temperature, 1 = pressure, plus
// the raw sample); each request yields one result on o_res_ch with the
// compensated value, the stored fine temperature and a divide-by-zero flag.
// The user must write calibration words through i_cfg_we/i_cfg_index/
// i_cfg_data only while no request is in flight; this is not enforced.
// A microcoded sequencer steps through the formula, each step a read state
// (S_READ) then an issue state (S_ISSUE); a multiply waits in S_WAIT for
// three 32x32 partial products and the handoff, and the pressure division
// waits for one quotient bit per cycle plus the handoff. One request is in
// flight at a time: i_req_ch.ready is high only while the block is idle, so
// a stalled receiver holds the result on o_res_ch and blocks new requests
// until it is taken.
// Reset clears the calibration registers and the fine temperature to zero.
module temp_pressure_compensation (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tpc_req_if.sink     i_req_ch,
    tpc_res_if.source   o_res_ch,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    tpc_pkg::t_cmd  cmd;
    tpc_pkg::t_stat stat;
    logic [31:0]    result;
    logic [31:0]    fine;

    tpc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_ch.valid),
        .i_req_type  (i_req_ch.req_type),
        .i_res_ready (o_res_ch.ready),
        .i_stat      (stat),
        .o_req_ready (i_req_ch.ready),
        .o_res_valid (o_res_ch.valid),
        .o_div_zero  (o_res_ch.div_zero),
        .o_cmd       (cmd)
    );

    tpc_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_raw       (i_req_ch.raw_reading),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_stat      (stat),
        .o_result    (result),
        .o_fine      (fine)
    );

    assign o_res_ch.result_value  = $signed(result);
    assign o_res_ch.fine_temp_out = $signed(fine);
endmodule

/* sim/temp_pressure_compensation_tb.sv */
module temp_pressure_compensation_tb;

    // Index 7 is not a register; writes to it must be ignored.
    localparam logic [2:0] CFG_UNUSED = 3'd7;
    localparam int TIMEOUT_UNITS = 3_000_000;
    localparam int DRAIN_CYCLES = 300;

    typedef struct {
        bit        is_cfg;
        bit [2:0]  idx;
        bit [31:0] data;
        bit        rtype;
        bit [19:0] raw;
        bit        typed;
        int        exp_value;
        int        exp_fine;
        bit        exp_dz;
    } t_step;

    typedef struct {
        int value;
        int fine;
        bit dz;
    } t_reading;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    tpc_req_if req_ch();
    tpc_res_if res_ch();

    temp_pressure_compensation DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_req_ch(req_ch.sink),
        .o_res_ch(res_ch.source),
        .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    bit [31:0] cal_word [7];
    int        fine_t;
    t_reading  expected_readings [$];
    t_step     steps [$];
    int        mismatches;
    int        send_idle_pct;
    int        recv_stall_pct;
    bit        quiet_stretch;
    bit        long_hold_request;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #TIMEOUT_UNITS;
        $display("temp_pressure_compensation_tb: errors");
        $finish;
    end

    function automatic int sat32(longint v);
        if (v > 64'sd2147483647) return 2147483647;
        if (v < -64'sd2147483648) return -2147483648;
        return int'(v);
    endfunction

    function automatic bit [63:0] asr64(bit [63:0] x, int n);
        longint s;
        s = x;
        return s >>> n;
    endfunction

    function automatic bit [63:0] sext16(bit [15:0] h);
        longint s;
        s = longint'($signed(h));
        return s;
    endfunction

    // Truncating division on 64-bit two's complement patterns.
    function automatic bit [63:0] div_trunc(bit [63:0] n, bit [63:0] d);
        bit [63:0] an, ad, q;
        an = n[63] ? -n : n;
        ad = d[63] ? -d : d;
        q = an / ad;
        return (n[63] != d[63]) ? -q : q;
    endfunction

    function automatic void write_cal_model(bit [2:0] idx, bit [31:0] data);
        if (idx == tpc_pkg::CFG_TEMP_CAL_1 || idx == tpc_pkg::CFG_PRESS_CAL_1)
            cal_word[idx] = {16'd0, data[15:0]};
        else if (idx != CFG_UNUSED)
            cal_word[idx] = data;
    endfunction

    function automatic t_reading compensate(bit rtype, bit [19:0] raw);
        t_reading r;
        longint t1, t2, t3, a, b, tv1, tv2;
        bit [63:0] v1, v2, p, q;
        r.dz = 1'b0;
        if (!rtype) begin
            t1 = cal_word[tpc_pkg::CFG_TEMP_CAL_1][15:0];
            t2 = longint'($signed(cal_word[tpc_pkg::CFG_TEMP_CAL_2_3][15:0]));
            t3 = longint'($signed(cal_word[tpc_pkg::CFG_TEMP_CAL_2_3][31:16]));
            a = longint'(raw >> 3) - t1 * 2;
            b = longint'(raw >> 4) - t1;
            tv1 = (a * t2) >>> 11;
            tv2 = (((b * b) >>> 12) * t3) >>> 14;
            fine_t = sat32(tv1 + tv2);
            r.value = sat32((longint'(fine_t) * 5 + 128) >>> 8);
        end else begin
            v1 = longint'(fine_t) - 128000;
            v2 = v1 * v1 * sext16(cal_word[tpc_pkg::CFG_PRESS_CAL_6_7][15:0]);
            v2 += (v1 * sext16(cal_word[tpc_pkg::CFG_PRESS_CAL_4_5][31:16])) << 17;
            v2 += sext16(cal_word[tpc_pkg::CFG_PRESS_CAL_4_5][15:0]) << 35;
            v1 = asr64(v1 * v1 * sext16(cal_word[tpc_pkg::CFG_PRESS_CAL_2_3][31:16]), 8)
                 + ((v1 * sext16(cal_word[tpc_pkg::CFG_PRESS_CAL_2_3][15:0])) << 12);
            v1 = asr64(((64'd1 << 47) + v1)
                       * {48'd0, cal_word[tpc_pkg::CFG_PRESS_CAL_1][15:0]}, 33);
            if (v1 == 0) begin
                r.dz = 1'b1;
                r.value = 0;
            end else begin
                p = 64'd1048576 - {44'd0, raw};
                p = div_trunc(((p << 31) - v2) * 64'd3125, v1);
                q = asr64(p, 13);
                v1 = asr64(sext16(cal_word[tpc_pkg::CFG_PRESS_CAL_8_9][31:16]) * q * q, 25);
                v2 = asr64(sext16(cal_word[tpc_pkg::CFG_PRESS_CAL_8_9][15:0]) * p, 19);
                p = asr64(p + v1 + v2, 8)
                    + (sext16(cal_word[tpc_pkg::CFG_PRESS_CAL_6_7][31:16]) << 4);
                r.value = sat32(longint'(p));
            end
        end
        r.fine = fine_t;
        return r;
    endfunction

    function automatic t_step req_row(bit rtype, bit [19:0] raw);
        t_step s;
        s = '{default: 0};
        s.rtype = rtype;
        s.raw = raw;
        return s;
    endfunction

    function automatic t_step typed_row(bit rtype, bit [19:0] raw, int v, int f, bit dz);
        t_step s;
        s = req_row(rtype, raw);
        s.typed = 1'b1;
        s.exp_value = v;
        s.exp_fine = f;
        s.exp_dz = dz;
        return s;
    endfunction

    function automatic t_step cfg_row(bit [2:0] idx, bit [31:0] data);
        t_step s;
        s = '{default: 0};
        s.is_cfg = 1'b1;
        s.idx = idx;
        s.data = data;
        return s;
    endfunction

    // Offer one request, optionally after a gap, and log its expectation on accept.
    task automatic send_request(bit rtype, bit [19:0] raw, int gap, bit typed, t_reading tr);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.req_type <= rtype;
        req_ch.raw_reading <= raw;
        do @(posedge i_clk); while (!req_ch.ready);
        if (typed) begin
            expected_readings.push_back(tr);
            if (!rtype) fine_t = tr.fine;
        end else begin
            expected_readings.push_back(compensate(rtype, raw));
        end
    endtask

    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_readings.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic load_calibration(bit [31:0] words [8]);
        wait_idle();
        for (int i = 0; i < 8; i++) begin
            i_cfg_we <= 1'b1;
            i_cfg_index <= i[2:0];
            i_cfg_data <= words[i];
            @(posedge i_clk);
            write_cal_model(i[2:0], words[i]);
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic int pick_gap();
        if (quiet_stretch || $urandom_range(99) >= send_idle_pct) return 0;
        return $urandom_range(1, 6);
    endfunction

    // Receiver: random stalls, plus one long hold-off on request.
    initial begin
        int hold_left;
        hold_left = 0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold_request) begin
                long_hold_request = 1'b0;
                hold_left = 2000;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= quiet_stretch || ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        t_reading want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (expected_readings.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result value=%0d fine=%0d dz=%0b",
                             res_ch.result_value, res_ch.fine_temp_out, res_ch.div_zero);
            end else begin
                want = expected_readings.pop_front();
                if (res_ch.result_value !== want.value || res_ch.fine_temp_out !== want.fine
                        || res_ch.div_zero !== want.dz) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected value=%0d fine=%0d dz=%0b, got %0d %0d %0b",
                                 want.value, want.fine, want.dz, res_ch.result_value,
                                 res_ch.fine_temp_out, res_ch.div_zero);
                end
            end
        end
    end

    initial begin
        bit [31:0] words [8];
        t_reading tr;
        int guard;
        mismatches = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        quiet_stretch = 1'b0;
        long_hold_request = 1'b0;
        foreach (cal_word[i]) cal_word[i] = '0;
        fine_t = 0;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data <= '0;
        req_ch.valid <= 1'b0;
        req_ch.req_type <= 1'b0;
        req_ch.raw_reading <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // With all calibration at zero, temperature is zero and pressure hits a zero divisor.
        steps.push_back(typed_row(1'b1, 20'd0, 0, 0, 1'b1));
        steps.push_back(typed_row(1'b0, 20'd0, 0, 0, 1'b0));
        steps.push_back(typed_row(1'b0, 20'hFFFFF, 0, 0, 1'b0));
        steps.push_back(typed_row(1'b1, 20'hFFFFF, 0, 0, 1'b1));
        steps.push_back(cfg_row(tpc_pkg::CFG_TEMP_CAL_1, 32'd27504));
        steps.push_back(cfg_row(tpc_pkg::CFG_TEMP_CAL_2_3, {16'hFC18, 16'd26435}));
        steps.push_back(cfg_row(tpc_pkg::CFG_PRESS_CAL_1, 32'd36477));
        steps.push_back(cfg_row(tpc_pkg::CFG_PRESS_CAL_2_3, {16'd3024, 16'hD643}));
        steps.push_back(cfg_row(tpc_pkg::CFG_PRESS_CAL_4_5, {16'd140, 16'd2855}));
        steps.push_back(cfg_row(tpc_pkg::CFG_PRESS_CAL_6_7, {16'd15500, 16'hFFF9}));
        steps.push_back(cfg_row(tpc_pkg::CFG_PRESS_CAL_8_9, {16'd6000, 16'hC6F8}));
        steps.push_back(cfg_row(CFG_UNUSED, 32'hDEADBEEF));
        steps.push_back(req_row(1'b0, 20'd519888));
        steps.push_back(req_row(1'b1, 20'd415148));
        steps.push_back(req_row(1'b0, 20'd0));
        steps.push_back(req_row(1'b1, 20'd0));
        steps.push_back(req_row(1'b0, 20'hFFFFF));
        steps.push_back(req_row(1'b1, 20'hFFFFF));
        steps.push_back(req_row(1'b1, 20'h80000));
        steps.push_back(cfg_row(tpc_pkg::CFG_TEMP_CAL_1, 32'hFFFFFFFF));
        steps.push_back(cfg_row(tpc_pkg::CFG_TEMP_CAL_2_3, 32'h80007FFF));
        steps.push_back(cfg_row(tpc_pkg::CFG_PRESS_CAL_1, 32'h0000FFFF));
        steps.push_back(cfg_row(tpc_pkg::CFG_PRESS_CAL_2_3, 32'h80008000));
        steps.push_back(cfg_row(tpc_pkg::CFG_PRESS_CAL_4_5, 32'h7FFF7FFF));
        steps.push_back(cfg_row(tpc_pkg::CFG_PRESS_CAL_6_7, 32'h80007FFF));
        steps.push_back(cfg_row(tpc_pkg::CFG_PRESS_CAL_8_9, 32'h7FFF8000));
        steps.push_back(req_row(1'b0, 20'd0));
        steps.push_back(req_row(1'b1, 20'd0));
        steps.push_back(req_row(1'b0, 20'hFFFFF));
        steps.push_back(req_row(1'b1, 20'hFFFFF));
        steps.push_back(req_row(1'b1, 20'h7FFFF));

        for (int i = 0; i < steps.size(); i++) begin
            if (steps[i].is_cfg) begin
                if (i == 0 || !steps[i-1].is_cfg) wait_idle();
                i_cfg_we <= 1'b1;
                i_cfg_index <= steps[i].idx;
                i_cfg_data <= steps[i].data;
                @(posedge i_clk);
                write_cal_model(steps[i].idx, steps[i].data);
                if (i + 1 == steps.size() || !steps[i+1].is_cfg) i_cfg_we <= 1'b0;
            end else begin
                tr.value = steps[i].exp_value;
                tr.fine = steps[i].exp_fine;
                tr.dz = steps[i].exp_dz;
                send_request(steps[i].rtype, steps[i].raw, 0, steps[i].typed, tr);
            end
        end

        // Random part: five calibration sets, each walked through four idling phases.
        for (int set = 0; set < 5; set++) begin
            for (int w = 0; w < 8; w++) begin
                case (set)
                    0: words[w] = $urandom;
                    1: words[w] = 32'hFFFFFFFF;
                    2: words[w] = 32'h80008000;
                    3: words[w] = $urandom;
                    default: words[w] = (w == tpc_pkg::CFG_PRESS_CAL_1) ? 32'd0 : $urandom;
                endcase
            end
            if (set == 3) begin
                words[tpc_pkg::CFG_TEMP_CAL_1] = $urandom_range(20000, 32000);
                words[tpc_pkg::CFG_TEMP_CAL_2_3] = {16'hFC18, 16'd26435};
                words[tpc_pkg::CFG_PRESS_CAL_1] = $urandom_range(30000, 40000);
            end
            load_calibration(words);
            for (int n = 0; n < 250; n++) begin
                case (n / 63)
                    0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                    1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
                    2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
                    default: begin send_idle_pct = 18; recv_stall_pct = 18; end
                endcase
                quiet_stretch = (n % 63) < 8;
                if (set == 1 && n == 40) long_hold_request = 1'b1;
                if (set == 2 && n == 100) wait_idle();
                send_request(1'($urandom_range(1)),
                             ($urandom_range(9) == 0) ? ($urandom_range(1) ? 20'hFFFFF : 20'd0)
                                                      : 20'($urandom_range(20'hFFFFF)),
                             pick_gap(), 1'b0, tr);
            end
        end

        req_ch.valid <= 1'b0;
        quiet_stretch = 1'b1;
        guard = 0;
        while (expected_readings.size() != 0 && guard < 100000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_readings.size() == 0)
            $display("temp_pressure_compensation_tb: clean");
        else
            $display("temp_pressure_compensation_tb: errors");
        $finish;
    end
endmodule
